FILE: sv/uvst_pkg.sv
package uvst_pkg;

	// command kinds
	typedef enum logic {
		CMD_VERTEX = 1'b0,
		CMD_QUAD   = 1'b1
	} cmd_t;

	// configuration register indexes
	localparam logic [1:0] REG_RADIUS   = 2'd0;
	localparam logic [1:0] REG_SEGMENTS = 2'd1;
	localparam logic [1:0] REG_RINGS    = 2'd2;

	localparam int RAD_W        = 24;
	localparam int IDX_W        = 20;
	localparam int TEX_W        = 17;
	localparam int QUOT_W       = 33;
	localparam int CORDIC_MAX   = 24;
	localparam int SMALL_RADIUS = 6;

	localparam logic signed [31:0] GAIN_START = 32'sd652032874;
	localparam logic signed [31:0] ONE_Q30    = 32'sd1073741824;

	// arctangent of 2^-i in turns, Q0.32
	localparam logic signed [31:0] ATAN_TURNS [CORDIC_MAX] = '{
		32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
		32'sd42667331, 32'sd21354465, 32'sd10679838, 32'sd5340245,
		32'sd2670163, 32'sd1335087, 32'sd667544, 32'sd333772,
		32'sd166886, 32'sd83443, 32'sd41722, 32'sd20861,
		32'sd10430, 32'sd5215, 32'sd2608, 32'sd1304,
		32'sd652, 32'sd326, 32'sd163, 32'sd81
	};

	// one rotation lane
	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} cordic_t;

	// item info riding along the pipeline
	typedef struct packed {
		cmd_t              cmd;
		logic              bad;
		logic [IDX_W-1:0]  cur;
		logic [TEX_W-1:0]  tex_u;
		logic [TEX_W-1:0]  tex_v;
		logic [1:0]        qp;
		logic [1:0]        qt;
	} meta_t;

endpackage

FILE: sv/uvst_div_cell.sv
module uvst_div_cell #(
	parameter int CB    = 10,
	parameter bit FIRST = 1'b0
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic [CB-1:0]                den,
	input  logic [CB:0]                  rem_i,
	input  logic [uvst_pkg::QUOT_W-1:0]  quo_i,
	output logic [CB:0]                  rem_o,
	output logic [uvst_pkg::QUOT_W-1:0]  quo_o
);
	import uvst_pkg::*;

	logic [CB+1:0] trial;
	logic          ge;

	// one restoring quotient bit
	always_comb begin
		trial = FIRST ? {1'b0, rem_i} : {rem_i, 1'b0};
		ge    = trial >= {2'b00, den};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_o <= (CB+1)'(ge ? trial - {2'b00, den} : trial);
			quo_o <= {quo_i[QUOT_W-2:0], ge};
		end
	end

endmodule

FILE: sv/uvst_cordic_cell.sv
module uvst_cordic_cell #(
	parameter int IDX = 0
) (
	input  logic                clk,
	input  logic                en,
	input  uvst_pkg::cordic_t   a_i,
	input  uvst_pkg::cordic_t   b_i,
	output uvst_pkg::cordic_t   a_o,
	output uvst_pkg::cordic_t   b_o
);
	import uvst_pkg::*;

	function automatic cordic_t rotate(input cordic_t v);
		cordic_t r;
		logic signed [31:0] dx;
		logic signed [31:0] dy;
		dx = v.y >>> IDX;
		dy = v.x >>> IDX;
		if (!v.z[31]) begin
			r.x = v.x - dx;
			r.y = v.y + dy;
			r.z = v.z - ATAN_TURNS[IDX];
		end else begin
			r.x = v.x + dx;
			r.y = v.y - dy;
			r.z = v.z + ATAN_TURNS[IDX];
		end
		return r;
	endfunction

	// one micro-rotation on both angles
	always_ff @(posedge clk) begin
		if (en) begin
			a_o <= rotate(a_i);
			b_o <= rotate(b_i);
		end
	end

endmodule

FILE: sv/uv_sphere_tessellator.sv
// channel  | dir | tdata (low bit up)                                  | tuser   | tlast
// s_axis   | in  | ring_index[9:0], segment_index[19:10], 0 pad         | cmd     | -
// m_axis   | out | pos_x,pos_y,pos_z,normal_x/y/z,tex_u,tex_v,vertex_idx| range_error | last
// cfg      | in  | cfg_addr selects register, cfg_wdata 24 bits         | -       | -
// an item enters every cycle unless stalled; a vertex/bad item leaves one result, a quad six
// the pipeline is an input register, 33 divider cells, CORDIC_STAGES rotation cells, 5 stages
// the output register is loaded while a quad still drains only when its last index is taken
// one stall enable moves the whole chain, held whenever the tail slot is full and blocked
// arst_n clears valid bits and configuration to radius 1.0, 16 segments, 8 rings
module uv_sphere_tessellator #(
	parameter int COUNT_BITS    = 10,
	parameter int CORDIC_STAGES = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wen,
	input  logic [1:0]   cfg_addr,
	input  logic [23:0]  cfg_wdata,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [23:0]  s_tdata,   // ring_index, segment_index
	input  logic [0:0]   s_tuser,   // cmd
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [183:0] m_tdata,   // pos_x, pos_y, pos_z, normal_x/y/z, tex_u, tex_v, vertex_index
	output logic [0:0]   m_tuser,   // range_error
	output logic         m_tlast
);
	import uvst_pkg::*;

	localparam int CB     = COUNT_BITS;
	localparam int NC     = CORDIC_STAGES;
	localparam int DIV_N  = QUOT_W;
	localparam int END    = DIV_N + NC + 4;
	localparam int META_N = END + 1;

	// configuration
	logic [RAD_W-1:0] rad_q;
	logic [CB-1:0]    seg_q;
	logic [CB-1:0]    ring_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rad_q  <= RAD_W'(65536);
			seg_q  <= CB'(16);
			ring_q <= CB'(8);
		end else if (cfg_wen) begin
			unique case (cfg_addr)
				REG_RADIUS:   rad_q  <= cfg_wdata[RAD_W-1:0];
				REG_SEGMENTS: seg_q  <= CB'(cfg_wdata);
				REG_RINGS:    ring_q <= CB'(cfg_wdata);
				default: ;
			endcase
		end
	end

	logic en;

	// input decode
	logic [CB-1:0]      r_in;
	logic [CB-1:0]      s_in;
	cmd_t               cmd_in;
	logic               bad_in;
	logic [2*CB:0]      prod_in;
	logic [2*CB+1:0]    sum_in;
	meta_t              meta_in;

	always_comb begin
		r_in    = CB'(s_tdata[9:0]);
		s_in    = CB'(s_tdata[19:10]);
		cmd_in  = cmd_t'(s_tuser[0]);
		if (cmd_in == CMD_VERTEX)
			bad_in = (seg_q == '0) || (ring_q == '0) || (r_in > ring_q) || (s_in > seg_q);
		else
			bad_in = (seg_q == '0) || (ring_q == '0) || (r_in >= ring_q) || (s_in >= seg_q);
		prod_in = r_in * ({1'b0, seg_q} + (CB+1)'(1));
		sum_in  = (2*CB+2)'(prod_in) + (2*CB+2)'(s_in);
		meta_in = '0;
		meta_in.cmd = cmd_in;
		meta_in.bad = bad_in;
		meta_in.cur = IDX_W'(sum_in);
	end

	logic [CB-1:0] r_s1;
	logic [CB-1:0] s_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			r_s1 <= r_in;
			s_s1 <= s_in;
		end
	end

	// divider chains: ring/R and segment/S, one quotient bit per cell
	logic [CB:0]         rem_r [DIV_N+1];
	logic [CB:0]         rem_s [DIV_N+1];
	logic [QUOT_W-1:0]   quo_r [DIV_N+1];
	logic [QUOT_W-1:0]   quo_s [DIV_N+1];

	assign rem_r[0] = {1'b0, r_s1};
	assign rem_s[0] = {1'b0, s_s1};
	assign quo_r[0] = '0;
	assign quo_s[0] = '0;

	for (genvar k = 0; k < DIV_N; k++) begin : g_div
		uvst_div_cell #(.CB(CB), .FIRST(k == 0)) u_ring (
			.clk(clk), .en(en), .den(ring_q),
			.rem_i(rem_r[k]), .quo_i(quo_r[k]),
			.rem_o(rem_r[k+1]), .quo_o(quo_r[k+1])
		);
		uvst_div_cell #(.CB(CB), .FIRST(k == 0)) u_seg (
			.clk(clk), .en(en), .den(seg_q),
			.rem_i(rem_s[k]), .quo_i(quo_s[k]),
			.rem_o(rem_s[k+1]), .quo_o(quo_s[k+1])
		);
	end

	// angles in turns
	logic [31:0] phi;
	logic [31:0] theta;
	assign phi   = quo_r[DIV_N][32:1];
	assign theta = quo_s[DIV_N][31:0];

	// rotation chains
	cordic_t cp [NC+1];
	cordic_t ct [NC+1];

	always_comb begin
		cp[0].x = GAIN_START;
		cp[0].y = '0;
		cp[0].z = {2'b00, phi[29:0]};
		ct[0].x = GAIN_START;
		ct[0].y = '0;
		ct[0].z = {2'b00, theta[29:0]};
	end

	for (genvar j = 0; j < NC; j++) begin : g_cordic
		uvst_cordic_cell #(.IDX(j)) u_cell (
			.clk(clk), .en(en),
			.a_i(cp[j]), .b_i(ct[j]),
			.a_o(cp[j+1]), .b_o(ct[j+1])
		);
	end

	// item info shift line
	logic  v_q    [META_N];
	meta_t meta_q [META_N];
	meta_t meta_ld;

	always_comb begin
		meta_ld       = meta_q[DIV_N];
		meta_ld.tex_u = quo_s[DIV_N][32:16];
		meta_ld.tex_v = quo_r[DIV_N][32:16];
		meta_ld.qp    = phi[31:30];
		meta_ld.qt    = theta[31:30];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < META_N; k++)
				v_q[k] <= 1'b0;
		end else if (en) begin
			v_q[0] <= s_tvalid;
			for (int k = 1; k < META_N; k++)
				v_q[k] <= v_q[k-1];
		end
	end

	// divider results join the item info after the last divider cell
	always_ff @(posedge clk) begin
		if (en) begin
			meta_q[0] <= meta_in;
			for (int k = 1; k < META_N; k++) begin
				if (k == DIV_N + 1)
					meta_q[k] <= meta_ld;
				else
					meta_q[k] <= meta_q[k-1];
			end
		end
	end

	function automatic logic signed [31:0] clamp30(input logic signed [31:0] v);
		if (v > ONE_Q30)
			return ONE_Q30;
		else if (v < -ONE_Q30)
			return -ONE_Q30;
		return v;
	endfunction

	function automatic logic [15:0] neg_sat16(input logic signed [63:0] v);
		logic signed [63:0] n;
		n = -v;
		if (n > 64'sd32767)
			return 16'h7FFF;
		else if (n < -64'sd32768)
			return 16'h8000;
		return n[15:0];
	endfunction

	// quadrant fold and clamp
	logic signed [31:0] sp_c, cp_c, st_c, ct_c;

	always_comb begin
		unique case (meta_q[DIV_N+NC].qp)
			2'd0: begin cp_c = cp[NC].x;  sp_c = cp[NC].y;  end
			2'd1: begin cp_c = -cp[NC].y; sp_c = cp[NC].x;  end
			2'd2: begin cp_c = -cp[NC].x; sp_c = -cp[NC].y; end
			default: begin cp_c = cp[NC].y; sp_c = -cp[NC].x; end
		endcase
		unique case (meta_q[DIV_N+NC].qt)
			2'd0: begin ct_c = ct[NC].x;  st_c = ct[NC].y;  end
			2'd1: begin ct_c = -ct[NC].y; st_c = ct[NC].x;  end
			2'd2: begin ct_c = -ct[NC].x; st_c = -ct[NC].y; end
			default: begin ct_c = ct[NC].y; st_c = -ct[NC].x; end
		endcase
	end

	logic signed [31:0] sp_s2, cp_s2, st_s2, ct_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			sp_s2 <= clamp30(sp_c);
			cp_s2 <= clamp30(cp_c);
			st_s2 <= clamp30(st_c);
			ct_s2 <= clamp30(ct_c);
		end
	end

	// radius and normal products
	logic signed [56:0] rs_s3, rc_s3;
	logic signed [63:0] nsx_s3, nsz_s3;
	logic signed [31:0] cp_s3, st_s3, ct_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			rs_s3  <= $signed({1'b0, rad_q}) * sp_s2;
			rc_s3  <= $signed({1'b0, rad_q}) * cp_s2;
			nsx_s3 <= sp_s2 * ct_s2;
			nsz_s3 <= sp_s2 * st_s2;
			cp_s3  <= cp_s2;
			st_s3  <= st_s2;
			ct_s3  <= ct_s2;
		end
	end

	// ring radius, height and normals
	logic signed [56:0] rr_full, py_full;
	logic signed [26:0] rr_s4;
	logic [24:0]        py_s4;
	logic [15:0]        nx_s4, ny_s4, nz_s4;
	logic signed [31:0] st_s4, ct_s4;
	logic               big_rad;

	always_comb begin
		rr_full = (rs_s3 + 57'sd536870912) >>> 30;
		py_full = (rc_s3 + 57'sd536870912) >>> 30;
		big_rad = rad_q > RAD_W'(SMALL_RADIUS);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rr_s4 <= rr_full[26:0];
			py_s4 <= py_full[24:0];
			nx_s4 <= big_rad ? neg_sat16((nsx_s3 + 64'sd17592186044416) >>> 45) : '0;
			nz_s4 <= big_rad ? neg_sat16((nsz_s3 + 64'sd17592186044416) >>> 45) : '0;
			ny_s4 <= big_rad ? neg_sat16(64'((cp_s3 + 32'sd16384) >>> 15)) : '0;
			st_s4 <= st_s3;
			ct_s4 <= ct_s3;
		end
	end

	// horizontal position products
	logic signed [58:0] px_s5, pz_s5;
	logic [24:0]        py_s5;
	logic [15:0]        nx_s5, ny_s5, nz_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			px_s5 <= rr_s4 * ct_s4;
			pz_s5 <= rr_s4 * st_s4;
			py_s5 <= py_s4;
			nx_s5 <= nx_s4;
			ny_s5 <= ny_s4;
			nz_s5 <= nz_s4;
		end
	end

	logic signed [58:0] px_full, pz_full;
	assign px_full = (px_s5 + 59'sd536870912) >>> 30;
	assign pz_full = (pz_s5 + 59'sd536870912) >>> 30;

	// output register, valid quads drain six indices
	logic               out_v_q;
	logic               last_q;
	logic               err_q;
	logic               quad_q;
	logic [2:0]         k_q;
	logic [IDX_W-1:0]   cur_q;
	logic [IDX_W-1:0]   vidx_q;
	logic [24:0]        px_q, py_q, pz_q;
	logic [15:0]        nx_q, ny_q, nz_q;
	logic [TEX_W-1:0]   tu_q, tv_q;
	logic               take;
	logic               free;
	logic               vtx_ok;
	meta_t              tail;
	logic [IDX_W-1:0]   row;
	logic [IDX_W-1:0]   off_next;

	always_comb begin
		tail   = meta_q[END];
		take   = out_v_q && m_tready;
		free   = !out_v_q || (take && last_q);
		en     = !v_q[END] || free;
		vtx_ok = !tail.bad && (tail.cmd == CMD_VERTEX);
		row    = IDX_W'(seg_q) + IDX_W'(1);
		unique case (k_q)
			3'd0:    off_next = IDX_W'(1);
			3'd1:    off_next = row;
			3'd2:    off_next = row;
			3'd3:    off_next = IDX_W'(1);
			default: off_next = row + IDX_W'(1);
		endcase
	end

	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			last_q  <= 1'b0;
			err_q   <= 1'b0;
			quad_q  <= 1'b0;
			k_q     <= '0;
		end else if (v_q[END] && free) begin
			out_v_q <= 1'b1;
			err_q   <= tail.bad;
			quad_q  <= !tail.bad && (tail.cmd == CMD_QUAD);
			last_q  <= tail.bad || (tail.cmd == CMD_VERTEX);
			k_q     <= '0;
		end else if (take) begin
			if (last_q) begin
				out_v_q <= 1'b0;
			end else begin
				k_q    <= k_q + 3'd1;
				last_q <= (k_q == 3'd4);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_q[END] && free) begin
			cur_q  <= tail.cur;
			vidx_q <= tail.bad ? '0 : tail.cur;
			px_q   <= vtx_ok ? px_full[24:0] : '0;
			py_q   <= vtx_ok ? py_s5 : '0;
			pz_q   <= vtx_ok ? pz_full[24:0] : '0;
			nx_q   <= vtx_ok ? nx_s5 : '0;
			ny_q   <= vtx_ok ? ny_s5 : '0;
			nz_q   <= vtx_ok ? nz_s5 : '0;
			tu_q   <= vtx_ok ? tail.tex_u : '0;
			tv_q   <= vtx_ok ? tail.tex_v : '0;
		end else if (take && !last_q) begin
			vidx_q <= cur_q + off_next;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tlast  = last_q;
	assign m_tuser  = err_q;
	assign m_tdata  = {7'b0, vidx_q, tv_q, tu_q, nz_q, ny_q, nx_q, pz_q, py_q, px_q};

endmodule
